// File: rtl/core/bq_pkg.sv
`timescale 1ns / 1ps

package bq_pkg;

   localparam int SampleBits  = 24;
   localparam int CoefBits    = 32;
   localparam int FracBits    = 28;
   localparam int MaxChannels = 8;
   localparam int ChanBits    = $clog2(MaxChannels);
   localparam int CountBits   = 4;
   localparam int NumTaps     = 5;
   localparam int TapBits     = $clog2(NumTaps);
   localparam int ProdBits    = SampleBits + CoefBits;
   localparam int AccBits     = ProdBits + 3;
   localparam int CsrIdxBits  = 3;

   localparam logic [CsrIdxBits-1:0] CsrCoefB0 = CsrIdxBits'(0);
   localparam logic [CsrIdxBits-1:0] CsrCoefB1 = CsrIdxBits'(1);
   localparam logic [CsrIdxBits-1:0] CsrCoefB2 = CsrIdxBits'(2);
   localparam logic [CsrIdxBits-1:0] CsrCoefA1 = CsrIdxBits'(3);
   localparam logic [CsrIdxBits-1:0] CsrCoefA2 = CsrIdxBits'(4);
   localparam logic [CsrIdxBits-1:0] CsrActive = CsrIdxBits'(5);

   localparam logic OpFilter = 1'b0;
   localparam logic OpClear  = 1'b1;

   typedef logic signed [SampleBits-1:0] sample_type;
   typedef logic signed [CoefBits-1:0]   coef_type;
   typedef logic signed [ProdBits-1:0]   prod_type;
   typedef logic signed [AccBits-1:0]    acc_type;
   typedef logic [ChanBits-1:0]          chan_type;
   typedef logic [CountBits-1:0]         count_type;
   typedef logic [TapBits-1:0]           tap_type;

   typedef coef_type coef_array_type [NumTaps];

   localparam coef_array_type CoefReset = '{
      coef_type'(32'sh1000_0000), coef_type'(0), coef_type'(0), coef_type'(0), coef_type'(0)
   };

   typedef struct packed {
      logic valid;
      logic first;
      logic subtract;
   } mac_ctl_type;

   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type y1;
      sample_type y2;
   } hist_type;

endpackage

// File: rtl/core/bq_if.sv
`timescale 1ns / 1ps

interface bq_req_if;
   import bq_pkg::*;

   logic       valid;
   logic       ready;
   logic       operation;
   logic [2:0] channel;
   sample_type sample;

   modport source (output valid, output operation, output channel, output sample,
                   input ready);
   modport sink   (input valid, input operation, input channel, input sample,
                   output ready);
endinterface

interface bq_rsp_if;
   import bq_pkg::*;

   logic       valid;
   logic       ready;
   sample_type filtered;
   logic [2:0] out_channel;

   modport source (output valid, output filtered, output out_channel, input ready);
   modport sink   (input valid, input filtered, input out_channel, output ready);
endinterface

// File: rtl/core/bq_mac.sv
`timescale 1ns / 1ps

module bq_mac
   import bq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mac_ctl_type ctl,
   input  sample_type  operand,
   input  coef_type    coef,
   output acc_type     acc
);

   prod_type    prod_in;
   prod_type    prod_ff;
   mac_ctl_type ctl_ff;
   acc_type     acc_base;
   acc_type     acc_in;
   acc_type     acc_ff;

   assign prod_in  = ProdBits'(operand) * ProdBits'(coef);
   assign acc_base = ctl_ff.first ? '0 : acc_ff;
   assign acc_in   = ctl_ff.subtract ? acc_base - AccBits'(prod_ff)
                                     : acc_base + AccBits'(prod_ff);
   assign acc      = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// File: rtl/core/bq_hist.sv
`timescale 1ns / 1ps

module bq_hist
   import bq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       clear,
   input  chan_type   index,
   output hist_type   rd_data,
   input  logic       update,
   input  sample_type new_input,
   input  sample_type new_output
);

   sample_type x1_ff [MaxChannels];
   sample_type x2_ff [MaxChannels];
   sample_type y1_ff [MaxChannels];
   sample_type y2_ff [MaxChannels];

   assign rd_data.x1 = x1_ff[index];
   assign rd_data.x2 = x2_ff[index];
   assign rd_data.y1 = y1_ff[index];
   assign rd_data.y2 = y2_ff[index];

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < MaxChannels; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else if (update) begin
         x2_ff[index] <= x1_ff[index];
         x1_ff[index] <= new_input;
         y2_ff[index] <= y1_ff[index];
         y1_ff[index] <= new_output;
      end
   end

endmodule

// File: rtl/core/biquad_df1_multichannel_filter.sv
`timescale 1ns / 1ps

// Multichannel Direct Form I biquad with one shared multiply-accumulate unit.
// The request channel carries an operation, a channel number and a 24-bit
// sample; a filter word returns one response word with the filtered sample
// and the echoed channel, while a clear word zeroes every channel history
// and returns nothing. A filter word returns nothing when the active count
// is zero. Channels at or above the active count share history modulo it.
// A filter word passes an accept step, issues the five taps in turn to the
// single 24x32 bit multiplier, drains its product register and is rounded.
// The taps share the multiplier, so a new word is accepted only once the
// previous one has left the rounding step. The user must write
// coefficients and the active count through the csr port only while no
// word is in flight; the block itself does not enforce this.
// Reset sets b0 to unity, the other taps and the active count to zero, and
// clears all history. The response register holds a finished word while the
// receiver stalls; the next request is still accepted, and its result waits
// in the rounding step until the response register is free.

module biquad_df1_multichannel_filter
   import bq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bq_req_if.sink                req_port,
   bq_rsp_if.source              rsp_port,
   input  logic                  csr_write_enable,
   input  logic [CsrIdxBits-1:0] csr_index,
   input  logic [CoefBits-1:0]   csr_write_data
);

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StMac   = 2'd1;
   localparam logic [1:0] StDrain = 2'd2;
   localparam logic [1:0] StDone  = 2'd3;

   localparam int QuotBits = AccBits - FracBits;
   localparam acc_type RoundHalf = acc_type'(longint'(1) << (FracBits - 1));
   localparam logic signed [QuotBits-1:0] SatMax =
      QuotBits'((longint'(1) << (SampleBits - 1)) - 1);
   localparam logic signed [QuotBits-1:0] SatMin =
      QuotBits'(-(longint'(1) << (SampleBits - 1)));
   localparam count_type MaxCount = CountBits'(MaxChannels);
   localparam tap_type TapLast = TapBits'(NumTaps - 1);
   localparam tap_type TapA1   = TapBits'(CsrCoefA1);

   function automatic chan_type chan_mod(input chan_type ch, input count_type n);
      count_type r;
      r = CountBits'(ch);
      for (int i = 0; i < MaxChannels - 1; i++) begin
         if (r >= n) begin
            r = r - n;
         end
      end
      return r[ChanBits-1:0];
   endfunction

   coef_type    coef_ff [NumTaps];
   count_type   active_ff;
   count_type   eff_count;
   logic [1:0]  state_ff;
   logic [1:0]  state_in;
   tap_type     tap_ff;
   tap_type     tap_in;
   sample_type  x_ff;
   chan_type    ch_ff;
   chan_type    h_ff;
   logic        req_accept;
   logic        start;
   logic        hist_clear;
   logic        finish;
   hist_type    hist;
   mac_ctl_type mac_ctl;
   sample_type  operand;
   coef_type    coef;
   acc_type     acc;
   acc_type     acc_rnd;
   logic signed [QuotBits-1:0] quot;
   sample_type  result;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   sample_type  rsp_filtered_ff;
   chan_type    rsp_channel_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumTaps; i++) begin
            coef_ff[i] <= CoefReset[i];
         end
         active_ff <= '0;
      end else if (csr_write_enable) begin
         for (int i = 0; i < NumTaps; i++) begin
            if (csr_index == CsrIdxBits'(i)) begin
               coef_ff[i] <= coef_type'(csr_write_data);
            end
         end
         if (csr_index == CsrActive) begin
            active_ff <= csr_write_data[CountBits-1:0];
         end
      end
   end

   assign eff_count  = (active_ff > MaxCount) ? MaxCount : active_ff;
   assign req_port.ready = (state_ff == StIdle);
   assign req_accept = req_port.valid && req_port.ready;
   assign hist_clear = req_accept && (req_port.operation == OpClear);
   assign start      = req_accept && (req_port.operation == OpFilter) && (eff_count != '0);
   assign finish     = (state_ff == StDone) && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         StIdle: begin
            tap_in = '0;
            if (start) begin
               state_in = StMac;
            end
         end
         StMac: begin
            if (tap_ff == TapLast) begin
               state_in = StDrain;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         StDrain: begin
            state_in = StDone;
         end
         StDone: begin
            if (finish) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff  <= req_port.sample;
         ch_ff <= req_port.channel;
         h_ff  <= chan_mod(req_port.channel, eff_count);
      end
   end

   // Tap order: b0*x, b1*x1, b2*x2, then a1*y1 and a2*y2 subtracted.
   always_comb begin
      unique case (tap_ff)
         TapBits'(0): operand = x_ff;
         TapBits'(1): operand = hist.x1;
         TapBits'(2): operand = hist.x2;
         TapBits'(3): operand = hist.y1;
         TapBits'(4): operand = hist.y2;
         default:     operand = '0;
      endcase
   end

   assign coef             = (tap_ff <= TapLast) ? coef_ff[tap_ff] : '0;
   assign mac_ctl.valid    = (state_ff == StMac);
   assign mac_ctl.first    = (tap_ff == '0);
   assign mac_ctl.subtract = (tap_ff >= TapA1);

   bq_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .operand (operand),
      .coef    (coef),
      .acc     (acc)
   );

   assign acc_rnd = acc + RoundHalf;
   assign quot    = acc_rnd[AccBits-1:FracBits];

   always_comb begin
      priority if (quot > SatMax) begin
         result = sample_type'(SatMax);
      end else if (quot < SatMin) begin
         result = sample_type'(SatMin);
      end else begin
         result = sample_type'(quot);
      end
   end

   bq_hist u_hist (
      .clock      (clock),
      .reset      (reset),
      .clear      (hist_clear),
      .index      (h_ff),
      .rd_data    (hist),
      .update     (finish),
      .new_input  (x_ff),
      .new_output (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_filtered_ff <= result;
         rsp_channel_ff  <= ch_ff;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.filtered    = rsp_filtered_ff;
   assign rsp_port.out_channel = rsp_channel_ff;

   a_start_enters_mac : assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == StMac) && (tap_ff == '0))
      else $error("filter word did not start the tap sequence");

   a_clear_no_result : assert property (@(posedge clock) disable iff (reset)
      hist_clear |=> (state_ff == StIdle) && (rsp_valid_ff == 1'b0 || $past(rsp_valid_ff)))
      else $error("clear word produced a result");

   a_first_on_tap0 : assert property (@(posedge clock) disable iff (reset)
      (mac_ctl.valid && mac_ctl.first) |-> (tap_ff == '0) && !mac_ctl.subtract)
      else $error("accumulator restarted on a wrong tap");

   a_finish_free_slot : assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && (rsp_filtered_ff == $past(result)))
      else $error("result lost on the way to the response register");

endmodule
